FILE: hw/rtl/ps2_scancode_to_ascii_with_leds_defines.svh
// Assertion macros for the PS/2 scan code translator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PS2_SCANCODE_TO_ASCII_WITH_LEDS_DEFINES_SVH
`define PS2_SCANCODE_TO_ASCII_WITH_LEDS_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PS2SC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define PS2SC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ps2sc_pkg.sv
// Shared types, scan codes and character ROM for the PS/2 scan code translator.
// No dependencies; used by ps2sc_char_map and the top level.
package ps2sc_pkg;

  localparam int CMD_QUEUE_DEPTH = 32;

  // Bytes exchanged with the keyboard.
  localparam logic [7:0] LED_CMD      = 8'hED;
  localparam logic [7:0] ACK_CODE     = 8'hFA;
  localparam logic [7:0] RESEND_CODE  = 8'hFE;
  localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] NUM_MAKE     = 8'h45;
  localparam logic [7:0] SCROLL_MAKE  = 8'h46;

  // LED bit masks.
  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  // Distance between upper and lower case letters.
  localparam logic [6:0] CASE_OFFSET = 7'h20;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;

  // One LED command in the queue: 0xED, followed by the LED byte if has_led is set.
  typedef struct packed {
    logic       has_led;
    logic [2:0] leds;
  } cmdq_rec_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] code;
  } char_res_t;

  // Result item as packed on the output stream, last field in the lowest bits.
  typedef struct packed {
    logic [2:0] fill;
    logic       queue_overflow;
    logic [2:0] led_state;
    logic [7:0] cmd_byte;
    logic       cmd_valid;
    logic [6:0] char_code;
    logic       char_valid;
  } result_t;

  // Set-1 make code to ASCII, unshifted or shifted. Letters come out upper case.
  function automatic logic [6:0] char_rom(input logic [6:0] code, input logic shifted);
    logic [6:0] ch;
    ch = '0;
    unique case (code)
      7'h02: ch = shifted ? 7'h21 : 7'h31;
      7'h03: ch = shifted ? 7'h40 : 7'h32;
      7'h04: ch = shifted ? 7'h23 : 7'h33;
      7'h05: ch = shifted ? 7'h24 : 7'h34;
      7'h06: ch = shifted ? 7'h25 : 7'h35;
      7'h07: ch = shifted ? 7'h5E : 7'h36;
      7'h08: ch = shifted ? 7'h26 : 7'h37;
      7'h09: ch = shifted ? 7'h2A : 7'h38;
      7'h0A: ch = shifted ? 7'h28 : 7'h39;
      7'h0B: ch = shifted ? 7'h29 : 7'h30;
      7'h0C: ch = shifted ? 7'h5F : 7'h2D;
      7'h0D: ch = shifted ? 7'h2B : 7'h3D;
      7'h10: ch = 7'h51;
      7'h11: ch = 7'h57;
      7'h12: ch = 7'h45;
      7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;
      7'h15: ch = 7'h59;
      7'h16: ch = 7'h55;
      7'h17: ch = 7'h49;
      7'h18: ch = 7'h4F;
      7'h19: ch = 7'h50;
      7'h1A: ch = shifted ? 7'h7B : 7'h5B;
      7'h1B: ch = shifted ? 7'h7D : 7'h5D;
      7'h1E: ch = 7'h41;
      7'h1F: ch = 7'h53;
      7'h20: ch = 7'h44;
      7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;
      7'h23: ch = 7'h48;
      7'h24: ch = 7'h4A;
      7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C;
      7'h27: ch = shifted ? 7'h3A : 7'h3B;
      7'h28: ch = shifted ? 7'h22 : 7'h27;
      7'h2B: ch = shifted ? 7'h7C : 7'h5C;
      7'h2C: ch = 7'h5A;
      7'h2D: ch = 7'h58;
      7'h2E: ch = 7'h43;
      7'h2F: ch = 7'h56;
      7'h30: ch = 7'h42;
      7'h31: ch = 7'h4E;
      7'h32: ch = 7'h4D;
      7'h33: ch = shifted ? 7'h3C : 7'h2C;
      7'h34: ch = shifted ? 7'h3E : 7'h2E;
      7'h35: ch = shifted ? 7'h3F : 7'h2F;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;
      7'h48: ch = 7'h38;
      7'h49: ch = 7'h39;
      7'h4A: ch = 7'h2D;
      7'h4B: ch = 7'h34;
      7'h4C: ch = 7'h35;
      7'h4D: ch = 7'h36;
      7'h4E: ch = 7'h2B;
      7'h4F: ch = 7'h31;
      7'h50: ch = 7'h32;
      7'h51: ch = 7'h33;
      7'h52: ch = 7'h30;
      7'h53: ch = 7'h2E;
      7'h73: ch = shifted ? 7'h5F : 7'h5C;
      7'h7D: ch = shifted ? 7'h7C : 7'h5C;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/ps2sc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ps2sc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ps2sc_char_map.sv
// Scan code to character translation with shift and CapsLock case handling.
// Depends on ps2sc_pkg for the character ROM.
module ps2sc_char_map (
  input  logic [7:0]          code,
  input  logic                shifted,
  input  logic                caps,
  output ps2sc_pkg::char_res_t result
);
  import ps2sc_pkg::*;

  logic [6:0] rom_ch;
  logic [6:0] ch;
  logic       is_letter;

  // Break codes and replies have the top bit set and never give a character.
  assign rom_ch    = code[7] ? 7'h00 : char_rom(code[6:0], shifted);
  assign is_letter = (rom_ch >= CHAR_UPPER_A) && (rom_ch <= CHAR_UPPER_Z);
  // Lower case unless exactly one of shift and CapsLock is active.
  assign ch        = (is_letter && (caps == shifted)) ? rom_ch + CASE_OFFSET : rom_ch;

  assign result.valid = (ch != 7'h00);
  assign result.code  = ch;

endmodule

FILE: hw/rtl/ps2_scancode_to_ascii_with_leds.sv
// Top level of the PS/2 set-1 scan code translator with lock LED command queue.
// Depends on ps2sc_pkg, ps2sc_char_map, ps2sc_ram and the assertion macro header.
//
//   Channel  Direction  Handshake                 Payload
//   s_*      in         s_tvalid / s_tready       s_tdata[7:0]  = scan_code
//   m_*      out        m_tvalid / m_tready       m_tdata[23:0] = result item
//   cfg_*    in         cfg_valid / cfg_ready     cfg_data[2:0] = initial_leds
//
// One item per cycle is accepted while the result side is not stalled; an item
// passes from the input register through the state update into the result register.
// The state update and the LED command queue head lookup are both combinational
// between the input and result registers.
// Reset is synchronous on rst and loads the queue with the pair 0xED, LEDs as one
// record, without a clearing pass. A config write restarts the keyboard and queue
// state the same way but keeps the input and result registers. When m_tready is low
// a full result register holds and s_tready falls when the input register is full.
module ps2_scancode_to_ascii_with_leds #(
  parameter int CMD_QUEUE_DEPTH = ps2sc_pkg::CMD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] scan_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] char_valid, [7:1] char_code, [8] cmd_valid,
                                 // [16:9] cmd_byte, [19:17] led_state,
                                 // [20] queue_overflow, [23:21] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // [2:0] initial_leds
);
  import ps2sc_pkg::*;

  `include "ps2_scancode_to_ascii_with_leds_defines.svh"

  // Byte count needs to hold the depth itself; record pointers only index it.
  localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam int PW = $clog2(CMD_QUEUE_DEPTH);
  localparam int RW = $bits(cmdq_rec_t);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Stream pipeline registers.
  logic       in_valid;
  logic [7:0] in_code;
  logic       out_valid;
  result_t    out_data;
  logic       advance;
  logic       step;

  // Keyboard state.
  logic [1:0] shift_bits, shift_bits_next;
  logic [2:0] leds, leds_next;
  logic       awaiting, awaiting_next;
  logic [7:0] inflight, inflight_next;

  // Command queue. Bytes are counted one by one; records hold one 0xED and an
  // optional LED byte. phase marks that the head record's 0xED has already gone out.
  logic [CW-1:0] qcount, qcount_next;
  logic [PW-1:0] rhead, rhead_next;
  logic [PW-1:0] rtail, rtail_next;
  logic          phase, phase_next;

  // Head record source: hsel picks the bypass register over the RAM read data.
  logic          hsel;
  cmdq_rec_t     hreg;
  cmdq_rec_t     head_rec;
  logic [RW-1:0] ram_rdata;

  logic          push_we;
  cmdq_rec_t     push_rec;
  logic          bypass;
  logic          pop;
  logic          rec_done;
  cmdq_rec_t     pop_rec;
  logic [2:0]    toggle;
  logic          resend;
  logic          overflow;
  logic          cmd_valid_c;
  logic [7:0]    cmd_byte_c;
  char_res_t     char_res;
  logic [2:0]    start_leds;

  assign advance   = !out_valid || m_tready;
  assign step      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign cfg_ready = 1'b1;

  assign start_leds = rst ? 3'b000 : cfg_data;

  ps2sc_char_map u_char_map (
    .code    (in_code),
    .shifted (shift_bits != 2'b00),
    .caps    ((leds & LED_CAPS) != 3'b000),
    .result  (char_res)
  );

  ps2sc_ram #(
    .WIDTH (RW),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (push_we),
    .waddr (rtail),
    .wdata (push_rec),
    .raddr (rhead_next),
    .rdata (ram_rdata)
  );

  assign head_rec = hsel ? hreg : cmdq_rec_t'(ram_rdata);

  // Per-item state update: scan code decode, LED queue push, then at most one send.
  always_comb begin
    shift_bits_next = shift_bits;
    leds_next       = leds;
    awaiting_next   = awaiting;
    inflight_next   = inflight;
    qcount_next     = qcount;
    rhead_next      = rhead;
    rtail_next      = rtail;
    phase_next      = phase;
    toggle          = 3'b000;
    resend          = 1'b0;
    overflow        = 1'b0;
    push_we         = 1'b0;
    push_rec        = '0;
    pop             = 1'b0;
    rec_done        = 1'b0;
    pop_rec         = head_rec;
    cmd_valid_c     = 1'b0;
    cmd_byte_c      = 8'h00;

    if (step) begin
      unique case (in_code)
        LSHIFT_MAKE:  shift_bits_next = shift_bits | 2'b01;
        RSHIFT_MAKE:  shift_bits_next = shift_bits | 2'b10;
        LSHIFT_BREAK: shift_bits_next = shift_bits & 2'b10;
        RSHIFT_BREAK: shift_bits_next = shift_bits & 2'b01;
        CAPS_MAKE:    toggle = LED_CAPS;
        NUM_MAKE:     toggle = LED_NUM;
        SCROLL_MAKE:  toggle = LED_SCROLL;
        ACK_CODE:     awaiting_next = 1'b0;
        RESEND_CODE:  resend = awaiting;
        default:      ;
      endcase

      if (toggle != 3'b000) begin
        leds_next        = leds ^ toggle;
        push_rec.leds    = leds ^ toggle;
        if (qcount <= CW'(CMD_QUEUE_DEPTH - 2)) begin
          push_we          = 1'b1;
          push_rec.has_led = 1'b1;
          qcount_next      = qcount + CW'(2);
        end else if (qcount != CW'(CMD_QUEUE_DEPTH)) begin
          // Only one slot left: keep the 0xED, drop the LED byte.
          push_we          = 1'b1;
          push_rec.has_led = 1'b0;
          qcount_next      = qcount + CW'(1);
          overflow         = 1'b1;
        end else begin
          overflow = 1'b1;
        end
        if (push_we) begin
          rtail_next = ptr_inc(rtail);
        end
      end

      if (resend) begin
        cmd_valid_c = 1'b1;
        cmd_byte_c  = inflight;
      end else if (!awaiting_next && (qcount_next != '0)) begin
        // An empty queue before the push means the head is the record just pushed.
        pop_rec       = (qcount == '0) ? push_rec : head_rec;
        pop           = 1'b1;
        cmd_valid_c   = 1'b1;
        cmd_byte_c    = phase ? {5'b00000, pop_rec.leds} : LED_CMD;
        inflight_next = cmd_byte_c;
        awaiting_next = 1'b1;
        qcount_next   = qcount_next - CW'(1);
        rec_done      = phase || !pop_rec.has_led;
        phase_next    = !rec_done;
        if (rec_done) begin
          rhead_next = ptr_inc(rhead);
        end
      end
    end
  end

  // A record written where the head will sit next cycle is not yet visible
  // through the RAM's registered read, so it is forwarded.
  assign bypass = push_we && (rtail == rhead_next);

  always_ff @(posedge clk) begin
    if (rst || cfg_valid) begin
      shift_bits <= 2'b00;
      leds       <= start_leds;
      awaiting   <= 1'b0;
      inflight   <= 8'h00;
      qcount     <= CW'(2);
      rhead      <= '0;
      rtail      <= PW'(1);
      phase      <= 1'b0;
      hsel       <= 1'b1;
      hreg       <= '{has_led: 1'b1, leds: start_leds};
    end else begin
      shift_bits <= shift_bits_next;
      leds       <= leds_next;
      awaiting   <= awaiting_next;
      inflight   <= inflight_next;
      qcount     <= qcount_next;
      rhead      <= rhead_next;
      rtail      <= rtail_next;
      phase      <= phase_next;
      if (bypass) begin
        hsel <= 1'b1;
        hreg <= push_rec;
      end else if (rec_done) begin
        hsel <= 1'b0;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      out_data.fill           <= 3'b000;
      out_data.queue_overflow <= overflow;
      out_data.led_state      <= leds_next;
      out_data.cmd_byte       <= cmd_byte_c;
      out_data.cmd_valid      <= cmd_valid_c;
      out_data.char_code      <= char_res.code;
      out_data.char_valid     <= char_res.valid;
    end
  end

  `PS2SC_ASSERT_ALWAYS(a_qcount_bound, clk, rst, qcount <= CW'(CMD_QUEUE_DEPTH),
                       "command queue byte count exceeds its depth")
  `PS2SC_ASSERT_ALWAYS(a_phase_nonempty, clk, rst, !phase || (qcount != '0),
                       "half-sent LED record with an empty command queue")
  `PS2SC_ASSERT_NEXT(a_send_waits_ack, clk, rst, pop && !cfg_valid, awaiting,
                     "queued byte sent without waiting for acknowledge")

endmodule

FILE: test/ps2_scancode_checker.sv
// Scoreboard for the PS/2 scan code translator: watches the config, scan code and
// result channels, predicts each result item and compares it. Depends on ps2sc_pkg.
module ps2_scancode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  output int          fail_count,
  output int          results_owed
);
  import ps2sc_pkg::*;

  // Keyboard-side state as the translator should hold it.
  logic [1:0] shift_keys;     // bit0 left, bit1 right
  logic [2:0] lock_bits;      // bit2 caps, bit1 num, bit0 scroll
  logic       ack_pending;
  logic [7:0] sent_byte;
  logic [7:0] led_cmd_fifo[$];

  // Decoded results waiting for the output channel, oldest first.
  result_t    decoded_q[$];

  function automatic void restart_keyboard(input logic [2:0] leds);
    shift_keys  = '0;
    lock_bits   = leds;
    ack_pending = 1'b0;
    sent_byte   = '0;
    led_cmd_fifo.delete();
    led_cmd_fifo.push_back(LED_CMD);
    led_cmd_fifo.push_back({5'b0, leds});
  endfunction

  // Returns 1 when the byte does not fit and is dropped.
  function automatic logic queue_led_byte(input logic [7:0] b);
    if (led_cmd_fifo.size() >= CMD_QUEUE_DEPTH) return 1'b1;
    led_cmd_fifo.push_back(b);
    return 1'b0;
  endfunction

  // Set-1 legends; letters are upper case here and folded by the caller.
  function automatic logic [6:0] keymap_lookup(input logic [6:0] code, input logic shifted);
    logic [6:0] plain_ch;
    logic [6:0] shift_ch;
    plain_ch = 7'h00;
    case (code)
      7'h02: plain_ch = 7'h31;  7'h03: plain_ch = 7'h32;  7'h04: plain_ch = 7'h33;
      7'h05: plain_ch = 7'h34;  7'h06: plain_ch = 7'h35;  7'h07: plain_ch = 7'h36;
      7'h08: plain_ch = 7'h37;  7'h09: plain_ch = 7'h38;  7'h0A: plain_ch = 7'h39;
      7'h0B: plain_ch = 7'h30;  7'h0C: plain_ch = 7'h2D;  7'h0D: plain_ch = 7'h3D;
      7'h10: plain_ch = 7'h51;  7'h11: plain_ch = 7'h57;  7'h12: plain_ch = 7'h45;
      7'h13: plain_ch = 7'h52;  7'h14: plain_ch = 7'h54;  7'h15: plain_ch = 7'h59;
      7'h16: plain_ch = 7'h55;  7'h17: plain_ch = 7'h49;  7'h18: plain_ch = 7'h4F;
      7'h19: plain_ch = 7'h50;  7'h1A: plain_ch = 7'h5B;  7'h1B: plain_ch = 7'h5D;
      7'h1E: plain_ch = 7'h41;  7'h1F: plain_ch = 7'h53;  7'h20: plain_ch = 7'h44;
      7'h21: plain_ch = 7'h46;  7'h22: plain_ch = 7'h47;  7'h23: plain_ch = 7'h48;
      7'h24: plain_ch = 7'h4A;  7'h25: plain_ch = 7'h4B;  7'h26: plain_ch = 7'h4C;
      7'h27: plain_ch = 7'h3B;  7'h28: plain_ch = 7'h27;  7'h2B: plain_ch = 7'h5C;
      7'h2C: plain_ch = 7'h5A;  7'h2D: plain_ch = 7'h58;  7'h2E: plain_ch = 7'h43;
      7'h2F: plain_ch = 7'h56;  7'h30: plain_ch = 7'h42;  7'h31: plain_ch = 7'h4E;
      7'h32: plain_ch = 7'h4D;  7'h33: plain_ch = 7'h2C;  7'h34: plain_ch = 7'h2E;
      7'h35: plain_ch = 7'h2F;  7'h37: plain_ch = 7'h2A;  7'h39: plain_ch = 7'h20;
      7'h47: plain_ch = 7'h37;  7'h48: plain_ch = 7'h38;  7'h49: plain_ch = 7'h39;
      7'h4A: plain_ch = 7'h2D;  7'h4B: plain_ch = 7'h34;  7'h4C: plain_ch = 7'h35;
      7'h4D: plain_ch = 7'h36;  7'h4E: plain_ch = 7'h2B;  7'h4F: plain_ch = 7'h31;
      7'h50: plain_ch = 7'h32;  7'h51: plain_ch = 7'h33;  7'h52: plain_ch = 7'h30;
      7'h53: plain_ch = 7'h2E;  7'h73: plain_ch = 7'h5C;  7'h7D: plain_ch = 7'h5C;
      default: plain_ch = 7'h00;
    endcase
    // Only keys whose shifted legend differs are listed.
    shift_ch = plain_ch;
    case (code)
      7'h02: shift_ch = 7'h21;  7'h03: shift_ch = 7'h40;  7'h04: shift_ch = 7'h23;
      7'h05: shift_ch = 7'h24;  7'h06: shift_ch = 7'h25;  7'h07: shift_ch = 7'h5E;
      7'h08: shift_ch = 7'h26;  7'h09: shift_ch = 7'h2A;  7'h0A: shift_ch = 7'h28;
      7'h0B: shift_ch = 7'h29;  7'h0C: shift_ch = 7'h5F;  7'h0D: shift_ch = 7'h2B;
      7'h1A: shift_ch = 7'h7B;  7'h1B: shift_ch = 7'h7D;  7'h27: shift_ch = 7'h3A;
      7'h28: shift_ch = 7'h22;  7'h2B: shift_ch = 7'h7C;  7'h33: shift_ch = 7'h3C;
      7'h34: shift_ch = 7'h3E;  7'h35: shift_ch = 7'h3F;  7'h73: shift_ch = 7'h5F;
      7'h7D: shift_ch = 7'h7C;
      default: shift_ch = plain_ch;
    endcase
    return shifted ? shift_ch : plain_ch;
  endfunction

  function automatic result_t decode_scan_code(input logic [7:0] code);
    result_t    r;
    logic [6:0] ch;
    logic [2:0] flip;
    logic       drop;
    r    = '0;
    ch   = '0;
    flip = '0;
    drop = 1'b0;
    if (!code[7]) begin
      ch = keymap_lookup(code[6:0], shift_keys != 2'b00);
      // Upper case only when exactly one of shift and caps is active.
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z &&
          (((lock_bits & LED_CAPS) != 3'b000) == (shift_keys != 2'b00))) begin
        ch = ch + CASE_OFFSET;
      end
    end
    case (code)
      LSHIFT_MAKE:  shift_keys[0] = 1'b1;
      RSHIFT_MAKE:  shift_keys[1] = 1'b1;
      LSHIFT_BREAK: shift_keys[0] = 1'b0;
      RSHIFT_BREAK: shift_keys[1] = 1'b0;
      CAPS_MAKE:    flip = LED_CAPS;
      NUM_MAKE:     flip = LED_NUM;
      SCROLL_MAKE:  flip = LED_SCROLL;
      ACK_CODE:     ack_pending = 1'b0;
      RESEND_CODE: begin
        if (ack_pending) begin
          r.cmd_valid = 1'b1;
          r.cmd_byte  = sent_byte;
        end
      end
      default: ;
    endcase
    if (flip != 3'b000) begin
      lock_bits = lock_bits ^ flip;
      drop = queue_led_byte(LED_CMD);
      drop = queue_led_byte({5'b0, lock_bits}) | drop;
    end
    if (!r.cmd_valid && !ack_pending && led_cmd_fifo.size() > 0) begin
      sent_byte   = led_cmd_fifo.pop_front();
      ack_pending = 1'b1;
      r.cmd_valid = 1'b1;
      r.cmd_byte  = sent_byte;
    end
    r.char_valid     = (ch != 7'h00);
    r.char_code      = ch;
    r.led_state      = lock_bits;
    r.queue_overflow = drop;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      restart_keyboard(3'b000);
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) restart_keyboard(cfg_data);
      if (s_tvalid && s_tready) decoded_q.push_back(decode_scan_code(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (decoded_q.size() == 0) begin
          if (fail_count < 10) $display("%0t: result item %h arrived with none pending",
                                        $time, m_tdata);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (got.char_valid !== want.char_valid || got.char_code !== want.char_code ||
              got.cmd_valid !== want.cmd_valid || got.cmd_byte !== want.cmd_byte ||
              got.led_state !== want.led_state ||
              got.queue_overflow !== want.queue_overflow) begin
            if (fail_count < 10) begin
              $display("%0t: expected char %b/%h cmd %b/%h leds %b ovf %b", $time,
                       want.char_valid, want.char_code, want.cmd_valid, want.cmd_byte,
                       want.led_state, want.queue_overflow);
              $display("%0t:      got char %b/%h cmd %b/%h leds %b ovf %b", $time,
                       got.char_valid, got.char_code, got.cmd_valid, got.cmd_byte,
                       got.led_state, got.queue_overflow);
            end
            fail_count++;
          end
        end
      end
    end
    results_owed = decoded_q.size();
  end

endmodule

FILE: test/ps2_scancode_to_ascii_with_leds_tb.sv
// Testbench top for the PS/2 scan code translator: clock, reset, scan code and config
// stimulus, result back-pressure and the verdict. Depends on ps2sc_pkg, the block and
// ps2_scancode_checker, which does all prediction and comparison.
module ps2_scancode_to_ascii_with_leds_tb;
  import ps2sc_pkg::*;

  // Worst case is far below this: about 1200 items, each at most a random source gap,
  // a random sink stall and both pipeline registers, plus one long hold-off.
  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 230;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;

  int          fail_count;
  int          results_owed;
  int          cycle_count = 0;

  // Idling controls for the source and the sink.
  bit          source_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  bit          hold_off    = 1'b0;
  bit          hold_done   = 1'b0;

  ps2_scancode_to_ascii_with_leds u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ps2_scancode_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a result item.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result sink. It alternates ready stretches with random stall bursts, and once on
  // request holds off for a long time so that both pipeline registers fill and the
  // block has to drop s_tready while the source keeps offering items.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Offers one scan code, sometimes after an idle burst, and returns at the falling
  // edge after it was taken. s_tvalid stays high so back-to-back items need no gap.
  task automatic send_scan_code(input logic [7:0] code);
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drops valid and waits until every result item is back and the pipeline is empty.
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the LED preset, which also restarts the translator state.
  task automatic load_led_preset(input logic [2:0] leds);
    cfg_valid <= 1'b1;
    cfg_data  <= leds;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_lock_key();
    case ($urandom_range(0, 2))
      0:       return CAPS_MAKE;
      1:       return NUM_MAKE;
      default: return SCROLL_MAKE;
    endcase
  endfunction

  // A stretch of keyboard traffic. Most of it is well formed: plain typing, shifted
  // words, and lock keys followed by the keyboard's acknowledge of both LED bytes,
  // with a resend now and then. The rest is stray acks and resends, bursts of lock
  // keys with no acks that run the LED command queue full, and arbitrary bytes.
  task automatic type_random_session(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned k;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_scan_code(8'($urandom_range(0, 127)));
        sent++;
      end else if (pick < 50) begin
        k = $urandom_range(1, 5);
        send_scan_code($urandom_range(0, 1) ? LSHIFT_MAKE : RSHIFT_MAKE);
        repeat (k) send_scan_code(8'($urandom_range(0, 127)));
        send_scan_code($urandom_range(0, 1) ? LSHIFT_BREAK : RSHIFT_BREAK);
        sent += k + 2;
      end else if (pick < 60) begin
        send_scan_code(pick_lock_key());
        send_scan_code($urandom_range(0, 3) == 0 ? RESEND_CODE : ACK_CODE);
        send_scan_code(ACK_CODE);
        send_scan_code(ACK_CODE);
        sent += 4;
      end else if (pick < 72) begin
        send_scan_code(ACK_CODE);
        sent++;
      end else if (pick < 77) begin
        send_scan_code(RESEND_CODE);
        sent++;
      end else if (pick < 80) begin
        k = $urandom_range(12, 20);
        repeat (k) send_scan_code(pick_lock_key());
        sent += k;
      end else begin
        send_scan_code(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [2:0] presets [0:4];
    presets[0] = 3'b111;
    presets[1] = 3'b000;
    presets[2] = 3'b101;
    presets[3] = 3'($urandom_range(0, 7));
    presets[4] = 3'b010;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening from the reset state (all LEDs off, 0xED and 0x00 queued).
    send_scan_code(8'h02);          // '1'; the first queued byte goes out too
    send_scan_code(ACK_CODE);       // ack releases the LED byte
    send_scan_code(RESEND_CODE);    // resend while a byte is in flight
    send_scan_code(ACK_CODE);
    send_scan_code(RESEND_CODE);    // resend with nothing in flight is ignored
    send_scan_code(8'h10);          // lower case q
    send_scan_code(LSHIFT_MAKE);
    send_scan_code(8'h10);          // upper case Q
    send_scan_code(8'h1C);          // shifted entry that gives no character
    send_scan_code(8'h2B);          // shifted entry that gives a vertical bar
    send_scan_code(RSHIFT_MAKE);
    send_scan_code(LSHIFT_BREAK);   // right shift still held
    send_scan_code(8'h35);
    send_scan_code(RSHIFT_BREAK);
    send_scan_code(CAPS_MAKE);      // caps on, LED pair queued and its 0xED sent
    send_scan_code(8'h1E);          // caps alone gives upper case
    send_scan_code(LSHIFT_MAKE);
    send_scan_code(8'h1E);          // caps and shift cancel
    send_scan_code(LSHIFT_BREAK);
    send_scan_code(NUM_MAKE);
    send_scan_code(SCROLL_MAKE);
    send_scan_code(8'h7F);          // highest make code
    send_scan_code(8'h80);          // lowest break code
    send_scan_code(8'hFF);
    send_scan_code(8'h00);
    send_scan_code(8'h73);
    send_scan_code(8'h7D);

    // Random phases, each under its own LED preset. The second phase carries the
    // long sink hold-off; the last one runs with no idling on either side.
    for (int p = 0; p < 5; p++) begin
      settle_idle();
      if (p == 4) begin
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      load_led_preset(presets[p]);
      if (p == 1) hold_off = 1'b1;
      type_random_session(PHASE_ITEMS);
    end
    settle_idle();

    if (fail_count == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: ps2_scancode_to_ascii_with_leds.f
+incdir+hw/rtl
hw/rtl/ps2sc_pkg.sv
hw/rtl/ps2sc_ram.sv
hw/rtl/ps2sc_char_map.sv
hw/rtl/ps2_scancode_to_ascii_with_leds.sv
test/ps2_scancode_checker.sv
test/ps2_scancode_to_ascii_with_leds_tb.sv
